// ===== design/cdad_pkg.sv =====
// Shared types, constants and calendar functions for the date adder.
`default_nettype none
package cdad_pkg;

  localparam int DayW   = 5;
  localparam int MonthW = 4;
  localparam int YearW  = 14;
  localparam int AddW   = 16;
  // Working day count: day of month plus the days still to add.
  localparam int AccW   = 17;
  localparam int QuotW  = 8;
  localparam int RemW   = 7;

  localparam logic [YearW-1:0] YEAR_MIN = 14'd1601;
  localparam logic [YearW-1:0] YEAR_MAX = 14'd9999;
  localparam logic [MonthW-1:0] MONTH_JAN = 4'd1;
  localparam logic [MonthW-1:0] MONTH_FEB = 4'd2;
  localparam logic [MonthW-1:0] MONTH_DEC = 4'd12;
  localparam logic [RemW-1:0] YEAR_IN_CENT_LAST = 7'd99;

  // floor(y / 100) == (y * 5243) >> 19 for every 14-bit year
  localparam logic [12:0] CENT_RECIP = 13'd5243;
  localparam int CENT_SHIFT = 19;
  localparam logic [6:0] CENT_LEN = 7'd100;

  localparam logic [DayW-1:0] MONTH_DAYS [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef struct packed {
    logic load;
    logic split;
    logic check;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic walk_done;
  } dp_stat_t;

  // Leap from year-within-century and century modulo four.
  function automatic logic leap_year(input logic [RemW-1:0] yc, input logic [1:0] c4);
    logic res;
    if (yc == '0) begin
      res = (c4 == 2'd0);
    end else begin
      res = (yc[1:0] == 2'd0);
    end
    return res;
  endfunction

  // Length of a month; zero for codes outside 1..12.
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                 input logic leap);
    logic [DayW-1:0] len;
    logic [MonthW-1:0] idx;
    idx = m - MONTH_JAN;
    if (m >= MONTH_JAN && m <= MONTH_DEC) begin
      len = MONTH_DAYS[idx];
      if (m == MONTH_FEB && leap) begin
        len = len + 5'd1;
      end
    end else begin
      len = '0;
    end
    return len;
  endfunction

endpackage
`default_nettype wire

// ===== design/cdad_datapath.sv =====
// Datapath: date registers, century split, validity check and month walk.
`default_nettype none
module cdad_datapath (
  input  wire logic                      clk,
  input  wire cdad_pkg::dp_cmd_t         cmd,
  input  wire logic [cdad_pkg::DayW-1:0]   in_day,
  input  wire logic [cdad_pkg::MonthW-1:0] in_month,
  input  wire logic [cdad_pkg::YearW-1:0]  in_year,
  input  wire logic [cdad_pkg::AddW-1:0]   in_days_to_add,
  output cdad_pkg::dp_stat_t             stat,
  output logic                           date_valid,
  output logic [cdad_pkg::DayW-1:0]      new_day,
  output logic [cdad_pkg::MonthW-1:0]    new_month,
  output logic [cdad_pkg::YearW-1:0]     new_year
);

  logic [cdad_pkg::AccW-1:0]   day_r;
  logic [cdad_pkg::MonthW-1:0] month_r;
  logic [cdad_pkg::YearW-1:0]  year_r;
  logic [cdad_pkg::AddW-1:0]   add_r;
  logic [cdad_pkg::QuotW-1:0]  quot_r;
  logic [cdad_pkg::RemW-1:0]   yc_r;
  logic [1:0]                  c4_r;
  logic                        ok_r;

  logic [26:0]                 prod;
  logic [14:0]                 cent_years;
  logic [cdad_pkg::YearW-1:0]  rem_full;
  logic [cdad_pkg::RemW-1:0]   rem;
  logic [cdad_pkg::DayW-1:0]   chk_len;
  logic [cdad_pkg::DayW-1:0]   cur_len;
  logic                        ok_nxt;

  assign prod       = 27'(year_r) * 27'(cdad_pkg::CENT_RECIP);
  assign cent_years = 15'(quot_r) * 15'(cdad_pkg::CENT_LEN);
  assign rem_full   = year_r - cent_years[cdad_pkg::YearW-1:0];
  assign rem        = rem_full[cdad_pkg::RemW-1:0];

  assign chk_len = cdad_pkg::month_len(month_r, cdad_pkg::leap_year(rem, quot_r[1:0]));
  assign cur_len = cdad_pkg::month_len(month_r, cdad_pkg::leap_year(yc_r, c4_r));

  assign ok_nxt = (year_r >= cdad_pkg::YEAR_MIN) && (year_r <= cdad_pkg::YEAR_MAX) &&
                  (month_r >= cdad_pkg::MONTH_JAN) && (month_r <= cdad_pkg::MONTH_DEC) &&
                  (day_r != '0) && (day_r <= cdad_pkg::AccW'(chk_len));

  assign stat.walk_done = !ok_r || (day_r <= cdad_pkg::AccW'(cur_len));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      day_r   <= cdad_pkg::AccW'(in_day);
      month_r <= in_month;
      year_r  <= in_year;
      add_r   <= in_days_to_add;
    end else if (cmd.split) begin
      quot_r <= prod[26:cdad_pkg::CENT_SHIFT];
    end else if (cmd.check) begin
      yc_r <= rem;
      c4_r <= quot_r[1:0];
      ok_r <= ok_nxt;
      // add the days only to a date that passed the check
      if (ok_nxt) begin
        day_r <= day_r + cdad_pkg::AccW'(add_r);
      end
    end else if (cmd.step) begin
      day_r <= day_r - cdad_pkg::AccW'(cur_len);
      if (month_r == cdad_pkg::MONTH_DEC) begin
        month_r <= cdad_pkg::MONTH_JAN;
        year_r  <= year_r + 14'd1;
        if (yc_r == cdad_pkg::YEAR_IN_CENT_LAST) begin
          yc_r <= '0;
          c4_r <= c4_r + 2'd1;
        end else begin
          yc_r <= yc_r + 7'd1;
        end
      end else begin
        month_r <= month_r + 4'd1;
      end
    end
  end

  assign date_valid = ok_r;
  assign new_day    = day_r[cdad_pkg::DayW-1:0];
  assign new_month  = month_r;
  assign new_year   = year_r;

endmodule
`default_nettype wire

// ===== design/cdad_ctrl.sv =====
// Controller state machine: sequences load, split, check and month walk.
`default_nettype none
module cdad_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire cdad_pkg::dp_stat_t stat,
  output cdad_pkg::dp_cmd_t       cmd,
  output logic                    busy,
  output logic                    out_strobe
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SPLIT = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_WALK  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        cmd.split = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        // advance one month per cycle until the day fits or the date failed the check
        if (stat.walk_done) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = (state_r == ST_DONE);

endmodule
`default_nettype wire

// ===== design/calendar_date_add_days_core.sv =====
// Top level: Gregorian date plus a count of days.
//
//   channel  ports                                         handshake
//   request  in_day in_month in_year in_days_to_add        start && !busy
//   result   out_date_valid out_new_day out_new_month      out_strobe, one cycle
//            out_new_year
//
// After a request is accepted the controller passes through the split, check, walk and
// done states, raising the result strobe in done and then returning to idle for the next
// request. The walk crosses M month boundaries (at most about 2160), stepping one month per
// cycle through a single subtract and month-length lookup.
// The year is split into century and year-in-century by a constant reciprocal
// multiply, then tracked by counters during the walk.
// Reset is synchronous, active low, and returns the controller to idle.
// The result registers hold their values until the next request is loaded; the receiver cannot stall.
`default_nettype none
module calendar_date_add_days_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [cdad_pkg::DayW-1:0]   in_day,
  input  wire logic [cdad_pkg::MonthW-1:0] in_month,
  input  wire logic [cdad_pkg::YearW-1:0]  in_year,
  input  wire logic [cdad_pkg::AddW-1:0]   in_days_to_add,
  output logic                             out_strobe,
  output logic                             out_date_valid,
  output logic [cdad_pkg::DayW-1:0]        out_new_day,
  output logic [cdad_pkg::MonthW-1:0]      out_new_month,
  output logic [cdad_pkg::YearW-1:0]       out_new_year
);

  cdad_pkg::dp_cmd_t  cmd;
  cdad_pkg::dp_stat_t stat;

  cdad_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy),
    .out_strobe (out_strobe)
  );

  cdad_datapath u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .in_day         (in_day),
    .in_month       (in_month),
    .in_year        (in_year),
    .in_days_to_add (in_days_to_add),
    .stat           (stat),
    .date_valid     (out_date_valid),
    .new_day        (out_new_day),
    .new_month      (out_new_month),
    .new_year       (out_new_year)
  );

`ifndef SYNTHESIS
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("result strobe outside a busy period");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe longer than one cycle");

  a_valid_date: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_date_valid) |->
      (out_new_month >= cdad_pkg::MONTH_JAN) && (out_new_month <= cdad_pkg::MONTH_DEC) &&
      (out_new_day != '0))
    else $error("valid result holds an impossible date");
`endif

endmodule
`default_nettype wire

// ===== sim/calendar_date_add_days_checker.sv =====
// Checker for the date adder: predicts each request's date sum and compares results.
module calendar_date_add_days_checker
  import cdad_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              busy,
  input  wire logic [DayW-1:0]   in_day,
  input  wire logic [MonthW-1:0] in_month,
  input  wire logic [YearW-1:0]  in_year,
  input  wire logic [AddW-1:0]   in_days_to_add,
  input  wire logic              out_strobe,
  input  wire logic              out_date_valid,
  input  wire logic [DayW-1:0]   out_new_day,
  input  wire logic [MonthW-1:0] out_new_month,
  input  wire logic [YearW-1:0]  out_new_year,
  output int                     fail_count,
  output int                     pending,
  output int                     checked,
  output int                     valid_dates
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              date_valid;
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
  } date_sum_t;

  date_sum_t pending_dates[$];

  function automatic bit is_leap(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // Only meaningful for months 1 to 12.
  function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
    int unsigned len;
    case (m)
      4, 6, 9, 11: len = 30;
      default:     len = 31;
    endcase
    if (m == MONTH_FEB) begin
      len = is_leap(y) ? 29 : 28;
    end
    return len;
  endfunction

  function automatic date_sum_t add_days_to_date(input logic [DayW-1:0] d,
                                                 input logic [MonthW-1:0] m,
                                                 input logic [YearW-1:0] y,
                                                 input logic [AddW-1:0] n);
    date_sum_t   sum;
    int unsigned dd;
    int unsigned mm;
    int unsigned yy;
    bit          ok;
    dd = d;
    mm = m;
    yy = y;
    ok = (yy >= YEAR_MIN) && (yy <= YEAR_MAX) && (mm >= MONTH_JAN) && (mm <= MONTH_DEC)
         && (dd >= 1);
    if (ok) begin
      ok = (dd <= month_days(mm, yy));
    end
    if (ok) begin
      dd = dd + n;
      // Walk whole months off the day count.
      while (dd > month_days(mm, yy)) begin
        dd = dd - month_days(mm, yy);
        if (mm == MONTH_DEC) begin
          mm = MONTH_JAN;
          yy = yy + 1;
        end else begin
          mm = mm + 1;
        end
      end
    end
    sum.date_valid = ok;
    sum.day        = dd[DayW-1:0];
    sum.month      = mm[MonthW-1:0];
    sum.year       = yy[YearW-1:0];
    return sum;
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count < 200) begin
      $display("%0t ns: mismatch: %s", $time, msg);
    end
    fail_count++;
  endtask

  always @(posedge clk) begin
    date_sum_t want;
    if (rst_n) begin
      // Retire the result before taking a new request seen at the same edge.
      if (out_strobe === 1'b1) begin
        if (pending_dates.size() == 0) begin
          report_mismatch("result strobe with no request outstanding");
        end else begin
          want = pending_dates.pop_front();
          checked++;
          if (want.date_valid) begin
            valid_dates++;
          end
          if (out_date_valid !== want.date_valid) begin
            report_mismatch($sformatf("date_valid %b, want %b", out_date_valid,
                                      want.date_valid));
          end
          if (out_new_day !== want.day) begin
            report_mismatch($sformatf("new_day %0d, want %0d", out_new_day, want.day));
          end
          if (out_new_month !== want.month) begin
            report_mismatch($sformatf("new_month %0d, want %0d", out_new_month, want.month));
          end
          if (out_new_year !== want.year) begin
            report_mismatch($sformatf("new_year %0d, want %0d", out_new_year, want.year));
          end
        end
      end
      if (start && !busy) begin
        pending_dates.push_back(add_days_to_date(in_day, in_month, in_year, in_days_to_add));
      end
    end
    pending = pending_dates.size();
  end

endmodule

// ===== sim/calendar_date_add_days_core_test.sv =====
// Testbench top for the date adder: drives requests and reports the verdict.
module calendar_date_add_days_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cdad_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic [DayW-1:0]   in_day = '0;
  logic [MonthW-1:0] in_month = '0;
  logic [YearW-1:0]  in_year = '0;
  logic [AddW-1:0]   in_days_to_add = '0;

  logic              busy;
  logic              out_strobe;
  logic              out_date_valid;
  logic [DayW-1:0]   out_new_day;
  logic [MonthW-1:0] out_new_month;
  logic [YearW-1:0]  out_new_year;

  int fail_count;
  int pending;
  int checked;
  int valid_dates;

  int requests;
  int long_adds;
  int fail_total;
  int random_left;
  int wait_cycles;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  calendar_date_add_days_core u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_day         (in_day),
    .in_month       (in_month),
    .in_year        (in_year),
    .in_days_to_add (in_days_to_add),
    .out_strobe     (out_strobe),
    .out_date_valid (out_date_valid),
    .out_new_day    (out_new_day),
    .out_new_month  (out_new_month),
    .out_new_year   (out_new_year)
  );

  calendar_date_add_days_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_day         (in_day),
    .in_month       (in_month),
    .in_year        (in_year),
    .in_days_to_add (in_days_to_add),
    .out_strobe     (out_strobe),
    .out_date_valid (out_date_valid),
    .out_new_day    (out_new_day),
    .out_new_month  (out_new_month),
    .out_new_year   (out_new_year),
    .fail_count     (fail_count),
    .pending        (pending),
    .checked        (checked),
    .valid_dates    (valid_dates)
  );

  // Present a request at the falling edge and hold it until the block takes it.
  task automatic send_request(input logic [DayW-1:0] d, input logic [MonthW-1:0] m,
                              input logic [YearW-1:0] y, input logic [AddW-1:0] n);
    @(negedge clk);
    in_day         = d;
    in_month       = m;
    in_year        = y;
    in_days_to_add = n;
    start          = 1'b1;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    requests++;
    if (n > 4000) begin
      long_adds++;
    end
  endtask

  task automatic pause_requests(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk);
      start = 1'b0;
    end
  endtask

  // Mostly short adds; long ones walk up to about 2160 months each.
  function automatic logic [AddW-1:0] random_add_count();
    int unsigned pick;
    logic [AddW-1:0] n;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      n = AddW'($urandom_range(0, 400));
    end else if (pick < 75) begin
      n = AddW'($urandom_range(0, 4000));
    end else if (pick < 95) begin
      n = AddW'($urandom);
    end else begin
      n = $urandom_range(0, 1) ? '1 : '0;
    end
    return n;
  endfunction

  task automatic send_random_request();
    int unsigned pick;
    int unsigned y;
    int unsigned m;
    int unsigned d;
    int unsigned len;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      y = 100 * $urandom_range(17, 99);
    end else if (pick < 35) begin
      y = $urandom_range(0, 1) ? $urandom_range(1601, 1610) : $urandom_range(9990, 9999);
    end else begin
      y = $urandom_range(1601, 9999);
    end
    m = ($urandom_range(0, 4) == 0) ? MONTH_FEB : $urandom_range(1, 12);
    len = u_checker.month_days(m, y);
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      d = len;
    end else if (pick == 3) begin
      d = 1;
    end else begin
      d = $urandom_range(1, len);
    end
    // Spoil about a quarter of the dates in one of several ways.
    if ($urandom_range(0, 99) >= 75) begin
      case ($urandom_range(0, 3))
        0: begin
          d = $urandom;
          m = $urandom;
          y = $urandom;
        end
        1: y = $urandom_range(0, 1) ? $urandom_range(0, 1600) : $urandom_range(10000, 16383);
        2: m = $urandom_range(0, 1) ? 0 : $urandom_range(13, 15);
        default: d = (len == 31 || $urandom_range(0, 1)) ? 0 : $urandom_range(len + 1, 31);
      endcase
    end
    send_request(d[DayW-1:0], m[MonthW-1:0], y[YearW-1:0], random_add_count());
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_request(5'd1, MONTH_JAN, YEAR_MIN, 16'd0);
    send_request(5'd31, MONTH_DEC, YEAR_MAX, 16'hFFFF);
    send_request(5'd31, MONTH_DEC, YEAR_MAX, 16'd0);
    send_request(5'd1, MONTH_JAN, YEAR_MIN, 16'hFFFF);
    send_request(5'd28, MONTH_FEB, 14'd2000, 16'd1);
    send_request(5'd28, MONTH_FEB, 14'd1900, 16'd1);
    send_request(5'd29, MONTH_FEB, 14'd2024, 16'd0);
    send_request(5'd29, MONTH_FEB, 14'd1900, 16'd5);
    send_request(5'd29, MONTH_FEB, 14'd2023, 16'd1);
    send_request(5'd30, MONTH_FEB, 14'd2024, 16'd1);
    send_request(5'd31, 4'd4, 14'd2021, 16'd1);
    send_request(5'd31, MONTH_DEC, 14'd2023, 16'd1);
    pause_requests(2);
    send_request(5'd31, MONTH_JAN, 14'd2024, 16'd29);
    send_request(5'd0, 4'd6, 14'd2020, 16'd10);
    send_request(5'd15, 4'd0, 14'd2020, 16'd10);
    send_request(5'd15, 4'd13, 14'd2020, 16'd10);
    send_request('1, '1, '1, '1);
    send_request('0, '0, '0, '0);
    send_request(5'd1, MONTH_JAN, 14'd1600, 16'd1);
    send_request(5'd1, MONTH_JAN, 14'd10000, 16'd1);
    send_request(5'd30, 4'd6, 14'd2020, 16'd365);
    send_request(5'd1, 4'd3, 14'd2000, 16'd36524);
    pause_requests(3);

    random_left = 270;
    while (random_left > 0) begin
      repeat ($urandom_range(1, 8)) begin
        if (random_left > 0) begin
          send_random_request();
          random_left--;
        end
      end
      if ($urandom_range(0, 3) != 0) begin
        pause_requests($urandom_range(1, 12));
      end
    end
    pause_requests(1);

    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 5000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (20) @(negedge clk);

    fail_total = fail_count + pending;
    if (pending != 0) begin
      $display("%0d requests never produced a result", pending);
    end
    $display("Sent %0d requests (%0d adding more than 4000 days); %0d results checked.",
             requests, long_adds, checked);
    $display("%0d started from a valid date, %0d were rejected as invalid.",
             valid_dates, checked - valid_dates);
    if (fail_total == 0) begin
      $display("calendar_date_add_days_core_test: PASS");
    end else begin
      $display("calendar_date_add_days_core_test: FAIL");
    end
    $finish;
  end

  // Hang guard, well above the slowest legal run.
  initial begin
    #60ms;
    $display("Run timed out");
    $display("calendar_date_add_days_core_test: FAIL");
    $finish;
  end

endmodule

// ===== calendar_date_add_days_core.f =====
design/cdad_pkg.sv
design/cdad_datapath.sv
design/cdad_ctrl.sv
design/calendar_date_add_days_core.sv
sim/calendar_date_add_days_checker.sv
sim/calendar_date_add_days_core_test.sv
